// ===== sv/adcps_pkg.sv =====
package adcps_pkg;

  // number of result bits of the square root, one cell per bit
  localparam int SQRT_N = 17;
  localparam int ROOT_W = SQRT_N;
  localparam int RAD_W  = 2 * SQRT_N;
  localparam int REM_W  = SQRT_N + 3;
  localparam int SUM_W  = 33;

  typedef struct packed {
    logic [15:0] center_x;
    logic [15:0] center_y;
    logic [13:0] radius;
    logic [15:0] fill_color;
    logic [7:0]  opacity;
    logic [10:0] width;
    logic [10:0] height;
  } cfg_t;

  // per pixel side data that rides along the pipeline
  typedef struct packed {
    logic        vld;
    logic        act;
    logic [15:0] dest;
  } meta_t;

  typedef struct packed {
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
    logic [RAD_W-1:0]  rad;
    meta_t             meta;
  } sq_t;

  typedef struct packed {
    logic        vld;
    logic [15:0] color;
    logic        we;
  } res_t;

endpackage

// ===== sv/adcps_front.sv =====
module adcps_front #(
  parameter int MAX_CANVAS_SIDE = 1024
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  adcps_pkg::cfg_t           i_cfg,
  input  logic                      i_valid,
  input  logic [9:0]                i_px,
  input  logic [9:0]                i_py,
  input  logic [15:0]               i_dest,
  output logic [adcps_pkg::SUM_W-1:0] o_sum,
  output adcps_pkg::meta_t          o_meta
);
  import adcps_pkg::*;

  logic signed [16:0] dx_r, dx_nxt, dy_r, dy_nxt;
  meta_t              m1_r, m1_nxt, m2_r, m3_r;
  logic signed [33:0] sqx, sqy;
  logic [31:0]        sqx_r, sqy_r;
  logic [SUM_W-1:0]   sum_r, sum_nxt;
  logic               on_canvas;

  // offsets of the pixel center from the disc center, 1/16 pixel
  assign dx_nxt = $signed({3'b000, i_px, 4'b1000} - {i_cfg.center_x[15], i_cfg.center_x});
  assign dy_nxt = $signed({3'b000, i_py, 4'b1000} - {i_cfg.center_y[15], i_cfg.center_y});

  assign on_canvas = ({1'b0, i_px} < i_cfg.width) && ({1'b0, i_py} < i_cfg.height) &&
                     (32'(i_px) < MAX_CANVAS_SIDE) && (32'(i_py) < MAX_CANVAS_SIDE);

  always_comb begin
    m1_nxt.vld  = i_valid;
    m1_nxt.act  = on_canvas && (i_cfg.radius != '0);
    m1_nxt.dest = i_dest;
  end

  assign sqx     = dx_r * dx_r;
  assign sqy     = dy_r * dy_r;
  assign sum_nxt = {1'b0, sqx_r} + {1'b0, sqy_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m1_r <= '0;
      m2_r <= '0;
      m3_r <= '0;
    end else if (en) begin
      m1_r <= m1_nxt;
      m2_r <= m1_r;
      m3_r <= m2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dx_r  <= dx_nxt;
      dy_r  <= dy_nxt;
      sqx_r <= sqx[31:0];
      sqy_r <= sqy[31:0];
      sum_r <= sum_nxt;
    end
  end

  assign o_sum  = sum_r;
  assign o_meta = m3_r;

endmodule

// ===== sv/adcps_sqrt_cell.sv =====
module adcps_sqrt_cell (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  adcps_pkg::sq_t   i_cell,
  output adcps_pkg::sq_t   o_cell
);
  import adcps_pkg::*;

  sq_t              cell_r, cell_nxt;
  logic [REM_W+1:0] cur, trial;

  // one restoring step: bring down two radicand bits, try root*4+1
  assign cur   = {i_cell.rem, i_cell.rad[RAD_W-1 -: 2]};
  assign trial = {3'b000, i_cell.root, 2'b01};

  always_comb begin
    cell_nxt      = i_cell;
    cell_nxt.rad  = {i_cell.rad[RAD_W-3:0], 2'b00};
    if (cur >= trial) begin
      cell_nxt.rem  = REM_W'(cur - trial);
      cell_nxt.root = {i_cell.root[ROOT_W-2:0], 1'b1};
    end else begin
      cell_nxt.rem  = cur[REM_W-1:0];
      cell_nxt.root = {i_cell.root[ROOT_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_r <= '0;
    end else if (en) begin
      cell_r <= cell_nxt;
    end
  end

  assign o_cell = cell_r;

endmodule

// ===== sv/adcps_back.sv =====
module adcps_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  adcps_pkg::cfg_t i_cfg,
  input  adcps_pkg::sq_t  i_cell,
  output adcps_pkg::res_t o_res
);
  import adcps_pkg::*;

  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [15:0] t;
    t = x + 16'd1 + {8'h00, x[15:8]};
    return t[15:8];
  endfunction

  // stage 1: rounded distance and coverage
  logic [ROOT_W:0]    rnd_dist;
  logic signed [19:0] diff;
  logic [11:0]        ramp;
  logic [7:0]         cov_nxt, cov_r;
  meta_t              m1_r, m2_r, m3_r;

  // stage 2: effective alpha
  logic [15:0] aprod;
  logic [7:0]  alpha_r;
  logic        we2_nxt, we2_r, we3_r;

  // stage 3: channel products
  logic [7:0]  ialpha;
  logic [12:0] rb_nxt, rf_nxt, bb_nxt, bf_nxt, rb_r, rf_r, bb_r, bf_r;
  logic [13:0] gb_nxt, gf_nxt, gb_r, gf_r;

  // stage 4: mix
  logic [7:0] mr, mg, mb;
  res_t       res_nxt, res_r;

  assign rnd_dist = {1'b0, i_cell.root} + (ROOT_W+1)'(i_cell.rem > {3'b000, i_cell.root});
  assign diff = $signed({6'b0, i_cfg.radius}) + 20'sd8 - $signed({2'b00, rnd_dist});
  assign ramp = {diff[3:0], 8'h00} - {8'h00, diff[3:0]};

  always_comb begin
    priority if (diff >= 20'sd16) begin
      cov_nxt = 8'd255;
    end else if (diff <= 20'sd0) begin
      cov_nxt = 8'd0;
    end else begin
      cov_nxt = ramp[11:4];
    end
  end

  assign aprod   = cov_r * i_cfg.opacity;
  assign we2_nxt = m1_r.act && (cov_r != '0) && (aprod[15:8] != '0);

  assign ialpha = 8'd255 - alpha_r;
  assign rb_nxt = m2_r.dest[15:11] * ialpha;
  assign gb_nxt = m2_r.dest[10:5] * ialpha;
  assign bb_nxt = m2_r.dest[4:0] * ialpha;
  assign rf_nxt = i_cfg.fill_color[15:11] * alpha_r;
  assign gf_nxt = i_cfg.fill_color[10:5] * alpha_r;
  assign bf_nxt = i_cfg.fill_color[4:0] * alpha_r;

  assign mr = div255({3'b000, rb_r} + {3'b000, rf_r});
  assign mg = div255({2'b00, gb_r} + {2'b00, gf_r});
  assign mb = div255({3'b000, bb_r} + {3'b000, bf_r});

  always_comb begin
    res_nxt.vld   = m3_r.vld;
    res_nxt.we    = we3_r;
    res_nxt.color = we3_r ? {mr[4:0], mg[5:0], mb[4:0]} : m3_r.dest;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m1_r  <= '0;
      m2_r  <= '0;
      m3_r  <= '0;
      res_r <= '0;
    end else if (en) begin
      m1_r  <= i_cell.meta;
      m2_r  <= m1_r;
      m3_r  <= m2_r;
      res_r <= res_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cov_r   <= cov_nxt;
      alpha_r <= aprod[15:8];
      we2_r   <= we2_nxt;
      we3_r   <= we2_r;
      rb_r    <= rb_nxt;
      gb_r    <= gb_nxt;
      bb_r    <= bb_nxt;
      rf_r    <= rf_nxt;
      gf_r    <= gf_nxt;
      bf_r    <= bf_nxt;
    end
  end

  assign o_res = res_r;

endmodule

// ===== sv/antialiased_disc_pixel_shader_top.sv =====
// anti-aliased filled disc shader for an rgb565 framebuffer
// input channel: in_valid/in_ready with pixel_x, pixel_y and the current
//   color of that pixel; one transfer per clock while in_ready is high
// result channel: out_valid/out_ready with the blended color and a write
//   enable; new_color equals dest_color when write_enable is low
// config channel: cfg_valid/cfg_ready with a 3-bit register index and
//   16-bit data, always ready; write only while no pixel is in flight
//   (0 center x, 1 center y, 2 radius, 3 fill color, 4 opacity,
//    5 canvas width, 6 canvas height; index 7 is ignored)
// pipeline: the transfer edge loads the first of 3 distance stages, then
//   come 17 square-root cells (one root bit each), 4 coverage/blend stages
//   and the output register
// throughput: one pixel per clock while the receiver keeps up
// a stalled receiver fills the output register and then a one-entry skid
//   register; in_ready then drops and the whole pipeline holds
// reset clears all valids and loads the register defaults
//   (opacity 255, canvas 320 x 240, everything else zero)
module antialiased_disc_pixel_shader_top #(
  parameter int MAX_CANVAS_SIDE = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [9:0]  in_pixel_x,
  input  logic [9:0]  in_pixel_y,
  input  logic [15:0] in_dest_color,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_new_color,
  output logic        out_write_enable,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import adcps_pkg::*;

  localparam logic [2:0] REG_CENTER_X = 3'd0;
  localparam logic [2:0] REG_CENTER_Y = 3'd1;
  localparam logic [2:0] REG_RADIUS   = 3'd2;
  localparam logic [2:0] REG_FILL     = 3'd3;
  localparam logic [2:0] REG_OPACITY  = 3'd4;
  localparam logic [2:0] REG_WIDTH    = 3'd5;
  localparam logic [2:0] REG_HEIGHT   = 3'd6;

  cfg_t cfg_r, cfg_nxt;

  // config writes
  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        REG_CENTER_X: cfg_nxt.center_x   = cfg_data;
        REG_CENTER_Y: cfg_nxt.center_y   = cfg_data;
        REG_RADIUS:   cfg_nxt.radius     = cfg_data[13:0];
        REG_FILL:     cfg_nxt.fill_color = cfg_data;
        REG_OPACITY:  cfg_nxt.opacity    = cfg_data[7:0];
        REG_WIDTH:    cfg_nxt.width      = cfg_data[10:0];
        REG_HEIGHT:   cfg_nxt.height     = cfg_data[10:0];
        default:      cfg_nxt            = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.center_x   <= '0;
      cfg_r.center_y   <= '0;
      cfg_r.radius     <= '0;
      cfg_r.fill_color <= '0;
      cfg_r.opacity    <= 8'd255;
      cfg_r.width      <= 11'd320;
      cfg_r.height     <= 11'd240;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // whole pipeline moves together unless the skid entry is occupied
  logic             pipe_en;
  logic             skid_valid_r, skid_valid_nxt;
  logic [SUM_W-1:0] dist_sq;
  meta_t            front_meta;
  sq_t              chain [SQRT_N+1];
  res_t             back_res;

  assign pipe_en  = !skid_valid_r;
  assign in_ready = pipe_en;

  // offsets, squares and sum of squares
  adcps_front #(
    .MAX_CANVAS_SIDE(MAX_CANVAS_SIDE)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (pipe_en),
    .i_cfg   (cfg_r),
    .i_valid (in_valid),
    .i_px    (in_pixel_x),
    .i_py    (in_pixel_y),
    .i_dest  (in_dest_color),
    .o_sum   (dist_sq),
    .o_meta  (front_meta)
  );

  always_comb begin
    chain[0].rem  = '0;
    chain[0].root = '0;
    chain[0].rad  = {1'b0, dist_sq};
    chain[0].meta = front_meta;
  end

  // row of square-root cells, each settles one root bit
  for (genvar i = 0; i < SQRT_N; i++) begin : g_cell
    adcps_sqrt_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (pipe_en),
      .i_cell (chain[i]),
      .o_cell (chain[i+1])
    );
  end

  // rounding, coverage, alpha and color mix
  adcps_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (pipe_en),
    .i_cfg  (cfg_r),
    .i_cell (chain[SQRT_N]),
    .o_res  (back_res)
  );

  // output register plus one skid entry
  logic        out_valid_r, out_valid_nxt;
  logic [15:0] out_color_r, out_color_nxt, skid_color_r;
  logic        out_we_r, out_we_nxt, skid_we_r;
  logic        arrive, out_free;

  assign arrive   = pipe_en && back_res.vld;
  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_color_nxt  = out_color_r;
    out_we_nxt     = out_we_r;
    skid_valid_nxt = skid_valid_r;
    priority if (out_free && skid_valid_r) begin
      out_valid_nxt  = 1'b1;
      out_color_nxt  = skid_color_r;
      out_we_nxt     = skid_we_r;
      skid_valid_nxt = 1'b0;
    end else if (out_free) begin
      out_valid_nxt = arrive;
      out_color_nxt = back_res.color;
      out_we_nxt    = back_res.we;
    end else if (arrive) begin
      skid_valid_nxt = 1'b1;
    end else begin
      skid_valid_nxt = skid_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_color_r <= out_color_nxt;
    out_we_r    <= out_we_nxt;
    if (!out_free && arrive) begin
      skid_color_r <= back_res.color;
      skid_we_r    <= back_res.we;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_new_color    = out_color_r;
  assign out_write_enable = out_we_r;

endmodule
